// ===== src/rfg_pkg.sv =====
// ----------------------------------------------------------------------------
// rfg_pkg : shared types and constants of the rectangle fill grid store
// Op codes, sequencer states and default sizes used by the RTL and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rfg_pkg;

  // Default grid geometry and cell width
  localparam int unsigned DefRows      = 64;
  localparam int unsigned DefCols      = 64;
  localparam int unsigned DefDataWidth = 32;

  // Fixed field widths of one beat
  localparam int unsigned CoordW = 6;
  localparam int unsigned ValueW = 32;

  // Width of the row-major address sum, enough for 1024 x 1024 cells
  localparam int unsigned FullAddrW = 21;

  // Command codes
  typedef enum logic [1:0] {
    OpLoad = 2'd0,
    OpFill = 2'd1,
    OpRead = 2'd2
  } op_e;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StFill = 3'b010,
    StResp = 3'b100
  } state_e;

endpackage : rfg_pkg

`default_nettype wire

// ===== src/rectangle_fill_grid_store.sv =====
// ----------------------------------------------------------------------------
// rectangle_fill_grid_store : grid of cells with point load, rectangle fill
// and point read, one shared address unit and one single-port cell memory.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake                     | Payload
//  ----------+-----------+-------------------------------+--------------------------
//  command   | in        | start high, busy low at edge  | op_i, top_row_i,
//            |           |                               | left_col_i, bottom_row_i,
//            |           |                               | right_col_i, data_value_i
//  result    | out       | result_valid_o for one cycle  | cell_value_o
//
//  A load to a point in the grid is written at its accepting edge.
//  A read's result shows in the following cycle.
//  A fill writes one cell per cycle through the single memory write port,
//  and busy stays high until every cell of the rectangle, clipped to the grid, is written.
//  Reset clears the sequencer only; cell contents are undefined until written.
//  The receiver cannot stall: each result beat is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_fill_grid_store
  import rfg_pkg::*;
#(
  parameter int unsigned ROWS       = DefRows,
  parameter int unsigned COLS       = DefCols,
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic [1:0]               op_i,
  input  wire logic [CoordW-1:0]        top_row_i,
  input  wire logic [CoordW-1:0]        left_col_i,
  input  wire logic [CoordW-1:0]        bottom_row_i,
  input  wire logic [CoordW-1:0]        right_col_i,
  input  wire logic signed [ValueW-1:0] data_value_i,
  output      logic                     result_valid_o,
  output      logic signed [ValueW-1:0] cell_value_o
);

  localparam int unsigned Depth = ROWS * COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [FullAddrW-1:0] RowsK   = FullAddrW'(ROWS);
  localparam logic [FullAddrW-1:0] ColsK   = FullAddrW'(COLS);
  localparam logic [CoordW-1:0]    LastRow = CoordW'(ROWS - 1);
  localparam logic [CoordW-1:0]    LastCol = CoordW'(COLS - 1);

  state_e state_q, state_d;

  logic [CoordW-1:0]           row_q, row_d;
  logic [CoordW-1:0]           col_q, col_d;
  logic [CoordW-1:0]           left_q, left_d;
  logic [CoordW-1:0]           last_row_q, last_row_d;
  logic [CoordW-1:0]           last_col_q, last_col_d;
  logic signed [DATA_WIDTH-1:0] fill_val_q, fill_val_d;
  logic signed [DATA_WIDTH-1:0] rd_data_q;
  logic                        rd_zero_q;

  logic signed [DATA_WIDTH-1:0] grid_q [Depth];

  logic                        accept;
  logic                        in_grid;
  logic                        fill_ok;
  logic [CoordW-1:0]           row_sel;
  logic [CoordW-1:0]           col_sel;
  logic [FullAddrW-1:0]        addr_full;
  logic [AddrW-1:0]            addr;
  logic                        wr_en;
  logic signed [DATA_WIDTH-1:0] wr_data;
  logic signed [DATA_WIDTH-1:0] in_cell;

  assign busy   = (state_q == StFill);
  assign accept = start && !busy;

  // Store the incoming value as a cell: sign extend or cut to the cell width
  assign in_cell = DATA_WIDTH'(data_value_i);

  // Check the beat's point against the grid and qualify a fill
  assign in_grid = (FullAddrW'(top_row_i) < RowsK) && (FullAddrW'(left_col_i) < ColsK);
  assign fill_ok = in_grid && (top_row_i <= bottom_row_i) && (left_col_i <= right_col_i);

  // Shared address unit: beat coordinates when idle, walk counters during a fill
  assign row_sel   = busy ? row_q : top_row_i;
  assign col_sel   = busy ? col_q : left_col_i;
  assign addr_full = FullAddrW'(row_sel) * ColsK + FullAddrW'(col_sel);
  assign addr      = addr_full[AddrW-1:0];

  // Write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_data = fill_val_q;
    if (busy) begin
      wr_en = 1'b1;
    end else if (accept && (op_i == OpLoad) && in_grid) begin
      wr_en   = 1'b1;
      wr_data = in_cell;
    end
  end

  // Sequencer and fill walk
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    left_d     = left_q;
    last_row_d = last_row_q;
    last_col_d = last_col_q;
    fill_val_d = fill_val_q;
    case (state_q)
      StFill: begin
        if (col_q == last_col_q) begin
          col_d = left_q;
          if (row_q == last_row_q) begin
            state_d = StIdle;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      StIdle, StResp: begin
        state_d = StIdle;
        if (accept) begin
          case (op_i)
            OpRead: begin
              state_d = StResp;
            end
            OpFill: begin
              if (fill_ok) begin
                state_d    = StFill;
                row_d      = top_row_i;
                col_d      = left_col_i;
                left_d     = left_col_i;
                fill_val_d = in_cell;
                last_row_d = (FullAddrW'(bottom_row_i) < RowsK) ? bottom_row_i : LastRow;
                last_col_d = (FullAddrW'(right_col_i) < ColsK) ? right_col_i : LastCol;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance walk registers and latch read flags
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    col_q      <= col_d;
    left_q     <= left_d;
    last_row_q <= last_row_d;
    last_col_q <= last_col_d;
    fill_val_q <= fill_val_d;
    if (accept && (op_i == OpRead)) begin
      rd_zero_q <= !in_grid;
    end
  end

  // Cell memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_q[addr] <= wr_data;
    end
    if (accept && (op_i == OpRead) && in_grid) begin
      rd_data_q <= grid_q[addr];
    end
  end

  // Present the result beat for one cycle
  assign result_valid_o = (state_q == StResp);
  assign cell_value_o   = rd_zero_q ? '0 : ValueW'(rd_data_q);

endmodule : rectangle_fill_grid_store

`default_nettype wire

// ===== src/rectangle_fill_grid_store_checker.sv =====
// ----------------------------------------------------------------------------
// rfg_checker : port-level checks of the rectangle fill grid store
// Ties result beats to accepted reads and busy to accepted fills.
// ----------------------------------------------------------------------------
`default_nettype none

module rfg_checker
  import rfg_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] op_i,
  input wire logic       result_valid_o
);

  logic read_acc;
  assign read_acc = start && !busy && (op_i == OpRead);

  // An accepted read gives a beat in the next cycle
  a_read_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_acc |=> result_valid_o)
    else $error("accepted read gave no result beat");

  // Every beat comes from a read accepted in the previous cycle
  a_beat_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(read_acc))
    else $error("result beat without an accepted read");

  // Loads, fills and unused codes give no beat
  a_no_beat_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i != OpRead)) |=> !result_valid_o)
    else $error("result beat after a non-read command");

  // Busy only rises after an accepted fill
  a_busy_from_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (op_i == OpFill)))
    else $error("busy rose without a fill");

  // No beat while a fill is running
  a_no_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat during a fill");

endmodule : rfg_checker

bind rectangle_fill_grid_store rfg_checker u_rfg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .op_i           (op_i),
  .result_valid_o (result_valid_o)
);

`default_nettype wire

// ===== tb/tb_rectangle_fill_grid_store.sv =====
// ----------------------------------------------------------------------------
// tb_rectangle_fill_grid_store : self-checking bench of the grid store
// Drives a table of directed load, fill, read and spare-code beats, then random beats,
// and compares every read result with the table's expected value or a cycle-free grid model kept here.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rectangle_fill_grid_store;
  import rfg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS       = DefRows;
  localparam int unsigned COLS       = DefCols;
  localparam int unsigned DATA_WIDTH = DefDataWidth;

  // Spare command code, ignored by the block
  localparam logic [1:0] OpSpare = 2'd3;

  localparam int NumDirected = 24;
  localparam int NumRandom   = 116;
  localparam int IdlePercent = 34;

  typedef struct packed {
    logic [1:0]        op;
    logic [CoordW-1:0] top_row;
    logic [CoordW-1:0] left_col;
    logic [CoordW-1:0] bottom_row;
    logic [CoordW-1:0] right_col;
    logic [ValueW-1:0] data;
  } grid_cmd_t;

  typedef struct packed {
    grid_cmd_t         cmd;
    logic              typed;
    logic [ValueW-1:0] want;
  } dir_row_t;

  // Directed beats; the grid is filled whole first so no cell is read unwritten
  dir_row_t dir_tab [NumDirected] = '{
    '{'{OpFill,  6'd0,  6'd0,  6'd63, 6'd63, 32'h8000_0000}, 1'b0, 32'h0},
    '{'{OpRead,  6'd0,  6'd0,  6'd0,  6'd0,  32'h0},         1'b1, 32'h8000_0000},
    '{'{OpRead,  6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF}, 1'b1, 32'h8000_0000},
    '{'{OpLoad,  6'd0,  6'd0,  6'd0,  6'd0,  32'h7FFF_FFFF}, 1'b0, 32'h0},
    '{'{OpRead,  6'd0,  6'd0,  6'd0,  6'd0,  32'h0},         1'b1, 32'h7FFF_FFFF},
    '{'{OpLoad,  6'd63, 6'd63, 6'd0,  6'd0,  32'hFFFF_FFFF}, 1'b0, 32'h0},
    '{'{OpRead,  6'd63, 6'd63, 6'd0,  6'd0,  32'h0},         1'b1, 32'hFFFF_FFFF},
    '{'{OpLoad,  6'd0,  6'd63, 6'd0,  6'd0,  32'h0},         1'b0, 32'h0},
    '{'{OpRead,  6'd0,  6'd63, 6'd0,  6'd0,  32'h0},         1'b1, 32'h0},
    // empty fills: top below bottom, then left beyond right
    '{'{OpFill,  6'd10, 6'd4,  6'd5,  6'd60, 32'h1234_5678}, 1'b0, 32'h0},
    '{'{OpRead,  6'd7,  6'd7,  6'd0,  6'd0,  32'h0},         1'b1, 32'h8000_0000},
    '{'{OpFill,  6'd4,  6'd40, 6'd60, 6'd39, 32'h0000_0001}, 1'b0, 32'h0},
    '{'{OpRead,  6'd30, 6'd39, 6'd0,  6'd0,  32'h0},         1'b1, 32'h8000_0000},
    // single cell rectangle
    '{'{OpFill,  6'd5,  6'd5,  6'd5,  6'd5,  32'h0000_0001}, 1'b0, 32'h0},
    '{'{OpRead,  6'd5,  6'd5,  6'd0,  6'd0,  32'h0},         1'b1, 32'h0000_0001},
    '{'{OpFill,  6'd62, 6'd1,  6'd63, 6'd62, 32'h5555_5555}, 1'b0, 32'h0},
    '{'{OpRead,  6'd63, 6'd62, 6'd0,  6'd0,  32'h0},         1'b1, 32'h5555_5555},
    '{'{OpRead,  6'd61, 6'd1,  6'd0,  6'd0,  32'h0},         1'b0, 32'h0},
    '{'{OpFill,  6'd20, 6'd10, 6'd40, 6'd50, 32'hAAAA_AAAA}, 1'b0, 32'h0},
    '{'{OpRead,  6'd40, 6'd50, 6'd0,  6'd0,  32'h0},         1'b0, 32'h0},
    '{'{OpRead,  6'd41, 6'd50, 6'd0,  6'd0,  32'h0},         1'b0, 32'h0},
    // spare code must leave the grid alone
    '{'{OpSpare, 6'd63, 6'd63, 6'd63, 6'd63, 32'h0},         1'b0, 32'h0},
    '{'{OpRead,  6'd63, 6'd63, 6'd63, 6'd63, 32'h0},         1'b1, 32'hFFFF_FFFF},
    '{'{OpRead,  6'd19, 6'd10, 6'd0,  6'd0,  32'h0},         1'b0, 32'h0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               op_i = OpLoad;
  logic [CoordW-1:0]        top_row_i = '0;
  logic [CoordW-1:0]        left_col_i = '0;
  logic [CoordW-1:0]        bottom_row_i = '0;
  logic [CoordW-1:0]        right_col_i = '0;
  logic signed [ValueW-1:0] data_value_i = '0;
  logic                     result_valid_o;
  logic signed [ValueW-1:0] cell_value_o;

  // Model of the cell array and the reads still owed by the block
  logic [DATA_WIDTH-1:0] grid_cells [ROWS*COLS];
  logic [ValueW-1:0]     read_values_due [$];
  logic [ValueW-1:0]     due_value;
  int                    fail_count = 0;
  bit                    idling_on = 1'b1;

  // Bounds of the last rectangle written, to aim reads at fresh data
  int last_top = 0, last_left = 0, last_bottom = 63, last_right = 63;

  rectangle_fill_grid_store #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .top_row_i     (top_row_i),
    .left_col_i    (left_col_i),
    .bottom_row_i  (bottom_row_i),
    .right_col_i   (right_col_i),
    .data_value_i  (data_value_i),
    .result_valid_o(result_valid_o),
    .cell_value_o  (cell_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one beat to the model grid; return the read value where there is one
  function automatic bit grid_apply(input grid_cmd_t cmd, output logic [ValueW-1:0] value);
    logic signed [63:0]           wide;
    logic [DATA_WIDTH-1:0]        cell_bits;
    logic signed [DATA_WIDTH-1:0] cell_s;
    int                           r_end, c_end;
    wide      = 64'(signed'(cmd.data));
    cell_bits = wide[DATA_WIDTH-1:0];
    value     = '0;
    case (cmd.op)
      OpLoad: begin
        if (cmd.top_row < ROWS && cmd.left_col < COLS) begin
          grid_cells[cmd.top_row*COLS + cmd.left_col] = cell_bits;
        end
        return 1'b0;
      end
      OpFill: begin
        if (cmd.top_row > cmd.bottom_row || cmd.left_col > cmd.right_col) return 1'b0;
        r_end = (cmd.bottom_row >= ROWS) ? ROWS - 1 : cmd.bottom_row;
        c_end = (cmd.right_col >= COLS) ? COLS - 1 : cmd.right_col;
        for (int r = cmd.top_row; r <= r_end; r++) begin
          for (int c = cmd.left_col; c <= c_end; c++) begin
            grid_cells[r*COLS + c] = cell_bits;
          end
        end
        return 1'b0;
      end
      OpRead: begin
        cell_s = '0;
        if (cmd.top_row < ROWS && cmd.left_col < COLS) begin
          cell_s = grid_cells[cmd.top_row*COLS + cmd.left_col];
        end
        wide  = 64'(cell_s);
        value = wide[ValueW-1:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Build one random beat: mostly small fills, loads and reads of fresh cells
  function automatic grid_cmd_t random_cmd();
    grid_cmd_t cmd;
    int        pick;
    cmd.top_row    = CoordW'($urandom_range(0, 63));
    cmd.left_col   = CoordW'($urandom_range(0, 63));
    cmd.bottom_row = CoordW'($urandom_range(0, 63));
    cmd.right_col  = CoordW'($urandom_range(0, 63));
    cmd.data       = $urandom();
    pick           = $urandom_range(0, 99);
    if (pick < 30) begin
      cmd.op = OpLoad;
    end else if (pick < 55) begin
      cmd.op = OpFill;
      // keep most rectangles small; now and then leave the corners wild
      if ($urandom_range(0, 11) != 0) begin
        cmd.bottom_row = (cmd.top_row > 60) ? 6'd63
                                            : CoordW'(cmd.top_row + $urandom_range(0, 3));
        cmd.right_col  = (cmd.left_col > 56) ? 6'd63
                                             : CoordW'(cmd.left_col + $urandom_range(0, 7));
      end
    end else if (pick < 92) begin
      cmd.op = OpRead;
      if ($urandom_range(0, 99) < 60) begin
        cmd.top_row  = CoordW'($urandom_range(last_top, last_bottom));
        cmd.left_col = CoordW'($urandom_range(last_left, last_right));
      end
    end else begin
      cmd.op = OpSpare;
    end
    return cmd;
  endfunction

  // Offer one beat, hold it until taken, then update the model
  task automatic issue_cmd(input grid_cmd_t cmd, input logic typed, input logic [ValueW-1:0] want);
    logic [ValueW-1:0] value;
    while (idling_on && $urandom_range(0, 99) < IdlePercent) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    op_i         <= cmd.op;
    top_row_i    <= cmd.top_row;
    left_col_i   <= cmd.left_col;
    bottom_row_i <= cmd.bottom_row;
    right_col_i  <= cmd.right_col;
    data_value_i <= cmd.data;
    do @(posedge clk_i); while (busy);
    if (grid_apply(cmd, value)) begin
      read_values_due = {read_values_due, (typed ? want : value)};
    end
    if (cmd.op == OpLoad) begin
      last_top    = cmd.top_row;
      last_bottom = cmd.top_row;
      last_left   = cmd.left_col;
      last_right  = cmd.left_col;
    end else if (cmd.op == OpFill && cmd.top_row <= cmd.bottom_row
                 && cmd.left_col <= cmd.right_col) begin
      last_top    = cmd.top_row;
      last_bottom = cmd.bottom_row;
      last_left   = cmd.left_col;
      last_right  = cmd.right_col;
    end
  endtask

  // Check each result beat against the oldest owed read
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (read_values_due.size() == 0) begin
        $error("cell_value: no read pending, got %0d", cell_value_o);
        fail_count++;
      end else begin
        due_value = read_values_due.pop_front();
        if (cell_value_o !== due_value) begin
          $error("cell_value: expected %0d, got %0d", $signed(due_value), cell_value_o);
          fail_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumDirected; i++) begin
      issue_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);
    end
    for (int i = 0; i < NumRandom; i++) begin
      // hold a stretch of back-to-back beats in the middle
      idling_on = !(i >= 60 && i < 95);
      issue_cmd(random_cmd(), 1'b0, '0);
    end
    start <= 1'b0;
    while (read_values_due.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (read_values_due.size() != 0) begin
      $error("cell_value: %0d reads never answered", read_values_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog well beyond a run of full-grid fills only
  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule : tb_rectangle_fill_grid_store

`default_nettype wire
